// File: hdl/lr_table_parse_driver_unit_macros.svh
// Assertion macros for the parser RTL.
`ifndef LR_TABLE_PARSE_DRIVER_UNIT_MACROS_SVH
`define LR_TABLE_PARSE_DRIVER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LRP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/lrp_pkg.sv
// Package with sizes, codes and the command type of the LR parser.
package lrp_pkg;
	localparam int NUM_STATES       = 256;
	localparam int NUM_TERMINALS    = 64;
	localparam int NUM_NONTERMINALS = 64;
	localparam int NUM_PRODUCTIONS  = 128;
	localparam int STACK_DEPTH      = 64;
	localparam int MAX_REDUCTIONS   = 15;

	localparam int ST_W     = $clog2(NUM_STATES);
	localparam int TERM_W   = $clog2(NUM_TERMINALS);
	localparam int NT_W     = $clog2(NUM_NONTERMINALS);
	localparam int PROD_AW  = $clog2(NUM_PRODUCTIONS);
	localparam int STK_AW   = $clog2(STACK_DEPTH);
	localparam int SP_W     = $clog2(STACK_DEPTH + 1);
	localparam int RED_W    = $clog2(MAX_REDUCTIONS + 1);
	localparam int ACT_AW   = ST_W + TERM_W;
	localparam int GOTO_AW  = ST_W + NT_W;
	localparam int ACT_DEPTH  = NUM_STATES * NUM_TERMINALS;
	localparam int GOTO_DEPTH = NUM_STATES * NUM_NONTERMINALS;
	localparam int CLR_DEPTH  = (ACT_DEPTH > GOTO_DEPTH) ? ACT_DEPTH : GOTO_DEPTH;
	localparam int CLR_W      = $clog2(CLR_DEPTH + 1);
	localparam int ACT_W    = 10;
	localparam int GOTO_W   = 9;
	localparam int PREC_W   = 10;

	localparam logic [2:0] OP_LOAD_ACT  = 3'd0;
	localparam logic [2:0] OP_LOAD_GOTO = 3'd1;
	localparam logic [2:0] OP_LOAD_PROD = 3'd2;
	localparam logic [2:0] OP_TOKEN     = 3'd3;
	localparam logic [2:0] OP_RESTART   = 3'd4;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_SHIFT  = 2'd1;
	localparam logic [1:0] KIND_REDUCE = 2'd2;

	localparam logic [2:0] STAT_LOADED = 3'd0;
	localparam logic [2:0] STAT_SHIFT  = 3'd1;
	localparam logic [2:0] STAT_REDUCE = 3'd2;
	localparam logic [2:0] STAT_SYNTAX = 3'd3;
	localparam logic [2:0] STAT_NOGOTO = 3'd4;
	localparam logic [2:0] STAT_FAULT  = 3'd5;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  state_index;
		logic [5:0]  symbol_index;
		logic [1:0]  entry_kind;
		logic [7:0]  entry_value;
		logic [6:0]  production_index;
		logic [3:0]  rhs_length;
		logic [5:0]  lhs_symbol;
		logic [15:0] line_number;
	} cmd_t;
endpackage

// File: hdl/lr_table_parse_driver_unit.sv
// Top level of the table-driven LR shift-reduce parser.
//
// Channel   Direction  Payload
// s_*       in         tuser: action; tdata: state, symbol, kind, value, production,
//                      length, lhs, line
// m_*       out        tuser: status; tdata: production, lhs, top, level, line; tlast
// cfg_*     in         start state register write
//
// A load or restart completes in the idle state; a token reads the action memory to
// shift, and each reduction adds registered reads of the production, stack (when the
// length is nonzero) and goto memories in turn.
// After reset the action and goto memories are cleared one entry per cycle, all 16384
// entries of each, while s_tready stays low.
// A stalled result register stalls the sequencer; a two-entry command queue keeps
// taking requests meanwhile until it is full.
module lr_table_parse_driver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // state_index, symbol_index, entry_kind, entry_value,
	                              // production_index, rhs_length, lhs_symbol, line_number
	input  logic [2:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // reduced_production, reduced_lhs, top_state,
	                              // stack_level, token_line
	output logic [2:0]  m_tuser,  // status
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data
);
	import lrp_pkg::*;

	logic clr_done;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	lrp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.clr_done(clr_done), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

	lrp_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.clr_done(clr_done), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast));
endmodule

// File: hdl/lrp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end
endmodule

// File: hdl/lrp_front.sv
// Input side: accepts requests, drops unknown codes and queues commands.
module lrp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [63:0]   s_tdata,
	input  logic [2:0]    s_tuser,
	input  logic          clr_done,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output lrp_pkg::cmd_t cmd
);
	import lrp_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cmd_t       in_cmd;

	assign s_tready  = (count_q != 2'd2) && clr_done;
	assign push      = s_tvalid && s_tready && (s_tuser <= OP_RESTART);
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	always_comb begin
		in_cmd.op               = s_tuser;
		in_cmd.state_index      = s_tdata[7:0];
		in_cmd.symbol_index     = s_tdata[13:8];
		in_cmd.entry_kind       = s_tdata[15:14];
		in_cmd.entry_value      = s_tdata[23:16];
		in_cmd.production_index = s_tdata[30:24];
		in_cmd.rhs_length       = s_tdata[34:31];
		in_cmd.lhs_symbol       = s_tdata[40:35];
		in_cmd.line_number      = s_tdata[56:41];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: hdl/lrp_back.sv
// Execution side: table stores, state stack, parse sequencer and result register.
`include "lr_table_parse_driver_unit_macros.svh"
module lrp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_data,
	output logic          clr_done,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  lrp_pkg::cmd_t cmd,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [47:0]   m_tdata,
	output logic [2:0]    m_tuser,
	output logic          m_tlast
);
	import lrp_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ACT   = 3'd1;
	localparam logic [2:0] S_PROD  = 3'd2;
	localparam logic [2:0] S_UNDER = 3'd3;
	localparam logic [2:0] S_GOTO  = 3'd4;

	logic [2:0]        st_q, st_d;
	logic [CLR_W-1:0]  clr_q;
	logic [7:0]        start_q;
	logic [SP_W-1:0]   sp_q, sp_d;
	logic [ST_W-1:0]   top_q, top_d;
	logic              err_q, err_d;
	logic [RED_W-1:0]  red_q, red_d;
	logic [TERM_W-1:0] sym_q;
	logic [15:0]       line_q;
	logic [PROD_AW-1:0] prod_q, prod_d;
	logic [NT_W-1:0]   lhs_q, lhs_d;

	logic              can_emit, emit, e_last;
	logic [2:0]        e_status;
	logic [6:0]        e_prod;
	logic [5:0]        e_lhs;
	logic [15:0]       e_line;
	logic              tok_take;

	logic              act_we, act_re;
	logic [ACT_AW-1:0] act_waddr, act_raddr;
	logic [ACT_W-1:0]  act_wdata, act_rd;
	logic              goto_we, goto_re;
	logic [GOTO_AW-1:0] goto_waddr, goto_raddr;
	logic [GOTO_W-1:0] goto_wdata, goto_rd;
	logic              prod_we, prod_re;
	logic [PROD_AW-1:0] prod_waddr, prod_raddr;
	logic [PREC_W-1:0] prod_wdata, prod_rd;
	logic              stk_we, stk_re;
	logic [STK_AW-1:0] stk_waddr, stk_raddr;
	logic [7:0]        stk_wdata, stk_rd;

	logic              m_valid_q;
	logic [2:0]        o_status_q;
	logic [6:0]        o_prod_q;
	logic [5:0]        o_lhs_q;
	logic [7:0]        o_top_q;
	logic [6:0]        o_level_q;
	logic [15:0]       o_line_q;
	logic              o_last_q;

	logic [1:0]        a_kind;
	logic [7:0]        a_val;
	logic [3:0]        p_len;
	logic [SP_W-1:0]   sp_pop;

	assign clr_done = (clr_q == CLR_W'(CLR_DEPTH));
	assign can_emit = !m_valid_q || m_tready;
	assign a_kind   = act_rd[9:8];
	assign a_val    = act_rd[7:0];
	assign p_len    = prod_rd[9:6];
	assign sp_pop   = sp_q - SP_W'(p_len);

	lrp_ram #(.WIDTH(ACT_W), .DEPTH(ACT_DEPTH)) u_act (
		.clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
		.re(act_re), .raddr(act_raddr), .rdata_q(act_rd));
	lrp_ram #(.WIDTH(GOTO_W), .DEPTH(GOTO_DEPTH)) u_goto (
		.clk(clk), .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
		.re(goto_re), .raddr(goto_raddr), .rdata_q(goto_rd));
	lrp_ram #(.WIDTH(PREC_W), .DEPTH(NUM_PRODUCTIONS)) u_prod (
		.clk(clk), .we(prod_we), .waddr(prod_waddr), .wdata(prod_wdata),
		.re(prod_re), .raddr(prod_raddr), .rdata_q(prod_rd));
	lrp_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(stk_re), .raddr(stk_raddr), .rdata_q(stk_rd));

	always_comb begin
		st_d = st_q;
		sp_d = sp_q;
		top_d = top_q;
		err_d = err_q;
		red_d = red_q;
		prod_d = prod_q;
		lhs_d = lhs_q;
		emit = 1'b0;
		e_status = STAT_LOADED;
		e_prod = 7'd0;
		e_lhs = 6'd0;
		e_line = 16'd0;
		e_last = 1'b1;
		cmd_ready = 1'b0;
		tok_take = 1'b0;
		act_we = 1'b0;
		act_waddr = {cmd.state_index, cmd.symbol_index};
		act_wdata = {(cmd.entry_kind == 2'd3) ? KIND_NONE : cmd.entry_kind, cmd.entry_value};
		act_re = 1'b0;
		act_raddr = {top_q, cmd.symbol_index};
		goto_we = 1'b0;
		goto_waddr = {cmd.state_index, cmd.symbol_index};
		goto_wdata = (cmd.entry_kind == KIND_SHIFT) ? {1'b1, cmd.entry_value} : '0;
		goto_re = 1'b0;
		goto_raddr = {top_q, prod_rd[5:0]};
		prod_we = 1'b0;
		prod_waddr = cmd.production_index;
		prod_wdata = {cmd.rhs_length, cmd.lhs_symbol};
		prod_re = 1'b0;
		prod_raddr = a_val[PROD_AW-1:0];
		stk_we = 1'b0;
		stk_waddr = sp_q[STK_AW-1:0];
		stk_wdata = a_val;
		stk_re = 1'b0;
		stk_raddr = STK_AW'(sp_pop - SP_W'(1));

		if (!clr_done) begin
			act_we = (clr_q < CLR_W'(ACT_DEPTH));
			act_waddr = clr_q[ACT_AW-1:0];
			act_wdata = '0;
			goto_we = (clr_q < CLR_W'(GOTO_DEPTH));
			goto_waddr = clr_q[GOTO_AW-1:0];
			goto_wdata = '0;
			stk_we = 1'b1;
			stk_waddr = '0;
			stk_wdata = 8'd0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (cmd_valid && can_emit) begin
						cmd_ready = 1'b1;
						emit = 1'b1;
						case (cmd.op)
							OP_LOAD_ACT: begin
								act_we = 1'b1;
							end
							OP_LOAD_GOTO: begin
								goto_we = 1'b1;
							end
							OP_LOAD_PROD: begin
								prod_we = 1'b1;
							end
							OP_RESTART: begin
								stk_we = 1'b1;
								stk_waddr = '0;
								stk_wdata = start_q;
								top_d = start_q;
								sp_d = SP_W'(1);
								err_d = 1'b0;
							end
							OP_TOKEN: begin
								tok_take = 1'b1;
								if (err_q) begin
									e_status = STAT_SYNTAX;
									e_line = cmd.line_number;
								end else begin
									emit = 1'b0;
									act_re = 1'b1;
									red_d = '0;
									st_d = S_ACT;
								end
							end
							default: begin
								emit = 1'b0;
							end
						endcase
					end
				end
				S_ACT: begin
					if (can_emit) begin
						e_line = line_q;
						if (a_kind == KIND_SHIFT) begin
							emit = 1'b1;
							st_d = S_IDLE;
							if (sp_q >= SP_W'(STACK_DEPTH)) begin
								e_status = STAT_FAULT;
								err_d = 1'b1;
							end else begin
								stk_we = 1'b1;
								sp_d = sp_q + SP_W'(1);
								top_d = a_val;
								e_status = STAT_SHIFT;
							end
						end else if (a_kind != KIND_REDUCE ||
								{1'b0, a_val} >= 9'(NUM_PRODUCTIONS)) begin
							emit = 1'b1;
							e_status = STAT_SYNTAX;
							err_d = 1'b1;
							st_d = S_IDLE;
						end else if (red_q >= RED_W'(MAX_REDUCTIONS)) begin
							emit = 1'b1;
							e_status = STAT_FAULT;
							err_d = 1'b1;
							st_d = S_IDLE;
						end else begin
							prod_re = 1'b1;
							prod_d = a_val[PROD_AW-1:0];
							st_d = S_PROD;
						end
					end
				end
				S_PROD: begin
					if (can_emit) begin
						lhs_d = prod_rd[5:0];
						if (SP_W'(p_len) >= sp_q) begin
							emit = 1'b1;
							e_status = STAT_FAULT;
							e_line = line_q;
							err_d = 1'b1;
							st_d = S_IDLE;
						end else if (p_len == 4'd0) begin
							goto_re = 1'b1;
							st_d = S_GOTO;
						end else begin
							sp_d = sp_pop;
							stk_re = 1'b1;
							st_d = S_UNDER;
						end
					end
				end
				S_UNDER: begin
					top_d = stk_rd;
					goto_re = 1'b1;
					goto_raddr = {stk_rd, lhs_q};
					st_d = S_GOTO;
				end
				S_GOTO: begin
					if (can_emit) begin
						emit = 1'b1;
						e_line = line_q;
						if (!goto_rd[8]) begin
							e_status = STAT_NOGOTO;
							err_d = 1'b1;
							st_d = S_IDLE;
						end else if (sp_q >= SP_W'(STACK_DEPTH)) begin
							e_status = STAT_FAULT;
							err_d = 1'b1;
							st_d = S_IDLE;
						end else begin
							stk_we = 1'b1;
							stk_wdata = goto_rd[7:0];
							sp_d = sp_q + SP_W'(1);
							top_d = goto_rd[7:0];
							red_d = red_q + RED_W'(1);
							e_status = STAT_REDUCE;
							e_prod = prod_q;
							e_lhs = lhs_q;
							e_last = 1'b0;
							act_re = 1'b1;
							act_raddr = {goto_rd[7:0], sym_q};
							st_d = S_ACT;
						end
					end
				end
				default: begin
					st_d = S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tok_take) begin
			sym_q <= cmd.symbol_index;
			line_q <= cmd.line_number;
		end
		prod_q <= prod_d;
		lhs_q <= lhs_d;
		if (emit) begin
			o_status_q <= e_status;
			o_prod_q <= e_prod;
			o_lhs_q <= e_lhs;
			o_top_q <= top_d;
			o_level_q <= sp_d;
			o_line_q <= e_line;
			o_last_q <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			clr_q <= '0;
			start_q <= 8'd0;
			sp_q <= SP_W'(1);
			top_q <= '0;
			err_q <= 1'b0;
			red_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (!clr_done) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (cfg_we) begin
				start_q <= cfg_data;
			end
			st_q <= st_d;
			sp_q <= sp_d;
			top_q <= top_d;
			err_q <= err_d;
			red_q <= red_d;
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = o_status_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {4'd0, o_line_q, o_level_q, o_top_q, o_lhs_q, o_prod_q};

	`LRP_ASSERT_NOW(a_sp_range, 1'b1, (sp_q != '0) && (sp_q <= SP_W'(STACK_DEPTH)), "stack level out of range")
	`LRP_ASSERT_NOW(a_no_cmd_in_clear, cmd_valid && cmd_ready, clr_done, "command taken during table clear")
	`LRP_ASSERT_NOW(a_red_bound, 1'b1, red_q <= RED_W'(MAX_REDUCTIONS), "reduction count exceeded")
	`LRP_ASSERT_NEXT(a_err_sticky, emit && (e_status == STAT_SYNTAX || e_status == STAT_NOGOTO || e_status == STAT_FAULT), err_q, "error result without error flag")
endmodule
